// ===== design/hdpf_pkg.sv =====
// ----------------------------------------------------------------------------
// hdpf_pkg
// Types and codes shared by the half-duplex packet framer, its channels and
// its checker.
// ----------------------------------------------------------------------------
package hdpf_pkg;

    // command codes on the input channel
    localparam logic CMD_MSG  = 1'b0;
    localparam logic CMD_LINE = 1'b1;

    // result kinds
    localparam logic [1:0] KIND_TX     = 2'd0;
    localparam logic [1:0] KIND_RX     = 2'd1;
    localparam logic [1:0] KIND_REFUSE = 2'd2;

    // receive buffer size in bytes
    localparam int RX_MAX = 15;
    localparam int RXW    = 4;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data;
        logic       last;
        logic       frame_error;
    } in_item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] byte_out;
        logic       end_of_run;
        logic       tx_on;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CAPTURE,
        ST_EMIT
    } state_t;

endpackage

// ===== design/hdpf_if.sv =====
// ----------------------------------------------------------------------------
// hdpf channel interfaces
// Valid/ready channels for the framer's input items and result items.
// ----------------------------------------------------------------------------
interface hdpf_in_if;
    import hdpf_pkg::*;

    logic     valid;
    logic     ready;
    in_item_t item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

interface hdpf_out_if;
    import hdpf_pkg::*;

    logic      valid;
    logic      ready;
    out_item_t item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

// ===== design/half_duplex_packet_framer.sv =====
// ----------------------------------------------------------------------------
// half_duplex_packet_framer
// Queues outgoing messages in a byte RAM and sends them byte by byte on line
// events; while idle on the line, collects received packets and emits them.
// ----------------------------------------------------------------------------
// No-result items leave the framer idle. A transmit or packet byte is read
// from RAM through the read, capture and emit states, which register the
// address, the read data and the output in turn; refusals and one-byte
// packets go straight to emit. Packet bytes replay in turn, waiting in emit
// while the output stalls; the input is ready again as the last result loads.
// Reset clears all control state; the RAMs and length table are not cleared.
// ----------------------------------------------------------------------------
module half_duplex_packet_framer #(
    parameter int QUEUE_DEPTH = 4,
    parameter int MSG_BYTES   = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    hdpf_in_if.sink    cmd_ch,
    hdpf_out_if.source res_ch
);
    import hdpf_pkg::*;

    localparam int QW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW  = $clog2(QUEUE_DEPTH + 1);
    localparam int SW  = CW + 1;
    localparam int FW  = $clog2(MSG_BYTES + 1);
    localparam int SDEPTH = QUEUE_DEPTH * MSG_BYTES;
    localparam int SAW = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;

    // control state
    state_t          state_reg, state_next;
    logic [QW-1:0]   head_reg, head_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [FW-1:0]   fill_reg, fill_next;
    logic            refused_reg, refused_next;
    logic [FW-1:0]   send_reg, send_next;
    logic            tx_on_reg, tx_on_next;
    logic [RXW-1:0]  rx_count_reg, rx_count_next;
    logic [RXW-1:0]  rx_rem_reg, rx_rem_next;
    logic [RXW-1:0]  run_idx_reg, run_idx_next;
    logic            out_valid_reg, out_valid_next;

    // payload state
    logic [RXW-1:0]  run_len_reg, run_len_next;
    logic            pend_run_reg, pend_run_next;
    logic [1:0]      pend_kind_reg, pend_kind_next;
    logic [7:0]      pend_byte_reg, pend_byte_next;
    logic            pend_end_reg, pend_end_next;
    logic            pend_tx_reg, pend_tx_next;
    logic [SAW-1:0]  rd_addr_reg, rd_addr_next;
    out_item_t       out_item_reg, out_item_next;
    logic [FW-1:0]   len_reg [QUEUE_DEPTH];

    // memory ports
    logic            store_we;
    logic [SAW-1:0]  store_waddr;
    logic [7:0]      store_rdata;
    logic            rx_we;
    logic [RXW-1:0]  rx_waddr;
    logic [7:0]      rx_rdata;
    logic            len_we;
    logic [QW-1:0]   len_waddr;
    logic [FW-1:0]   len_wdata;

    // working values
    logic [SW-1:0]   slot_sum;
    logic [QW-1:0]   fill_slot;
    logic [QW-1:0]   head_inc;
    logic [FW-1:0]   send_inc;
    logic            refuse;
    logic [FW-1:0]   fill_new;
    logic [CW-1:0]   count_dec;
    logic [RXW-1:0]  rx_count_new;
    logic [RXW-1:0]  rx_rem_dec;
    logic            run_last;
    in_item_t        item;

    assign item = cmd_ch.item;

    // slot being filled: (head + count) mod depth
    assign slot_sum  = SW'(head_reg) + SW'(count_reg);
    assign fill_slot = (slot_sum >= SW'(QUEUE_DEPTH)) ?
                       QW'(slot_sum - SW'(QUEUE_DEPTH)) : QW'(slot_sum);
    assign head_inc  = (head_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign send_inc  = send_reg + 1'b1;
    assign count_dec = count_reg - 1'b1;
    assign refuse    = refused_reg || ((fill_reg == '0) &&
                       (count_reg >= CW'(QUEUE_DEPTH)));
    assign rx_rem_dec = rx_rem_reg - 1'b1;
    assign run_last  = (run_idx_reg == run_len_reg - 1'b1);

    // handshake outputs
    assign cmd_ch.ready = (state_reg == ST_IDLE);
    assign res_ch.valid = out_valid_reg;
    assign res_ch.item  = out_item_reg;

    // next state and datapath
    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        fill_next      = fill_reg;
        refused_next   = refused_reg;
        send_next      = send_reg;
        tx_on_next     = tx_on_reg;
        rx_count_next  = rx_count_reg;
        rx_rem_next    = rx_rem_reg;
        run_idx_next   = run_idx_reg;
        run_len_next   = run_len_reg;
        pend_run_next  = pend_run_reg;
        pend_kind_next = pend_kind_reg;
        pend_byte_next = pend_byte_reg;
        pend_end_next  = pend_end_reg;
        pend_tx_next   = pend_tx_reg;
        rd_addr_next   = rd_addr_reg;
        out_item_next  = out_item_reg;
        out_valid_next = out_valid_reg && !res_ch.ready;
        store_we       = 1'b0;
        store_waddr    = SAW'(fill_slot) * SAW'(MSG_BYTES) + SAW'(fill_reg);
        rx_we          = 1'b0;
        rx_waddr       = rx_count_reg;
        len_we         = 1'b0;
        len_waddr      = fill_slot;
        fill_new       = fill_reg;
        len_wdata      = fill_new;
        rx_count_new   = rx_count_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_ch.valid)
                begin
                    if (item.cmd == CMD_MSG)
                    begin
                        // message byte
                        if (refuse)
                        begin
                            refused_next = 1'b1;
                            if (item.last)
                            begin
                                refused_next   = 1'b0;
                                fill_next      = '0;
                                pend_run_next  = 1'b0;
                                pend_kind_next = KIND_REFUSE;
                                pend_byte_next = 8'h00;
                                pend_end_next  = 1'b0;
                                pend_tx_next   = tx_on_reg;
                                state_next     = ST_EMIT;
                            end
                        end
                        else
                        begin
                            if (fill_reg < FW'(MSG_BYTES))
                            begin
                                store_we = 1'b1;
                                fill_new = fill_reg + 1'b1;
                            end
                            fill_next = fill_new;
                            if (item.last)
                            begin
                                len_we     = 1'b1;
                                len_wdata  = fill_new;
                                count_next = count_reg + 1'b1;
                                fill_next  = '0;
                                if (!tx_on_reg)
                                begin
                                    tx_on_next     = 1'b1;
                                    send_next      = '0;
                                    rd_addr_next   = SAW'(head_reg) * SAW'(MSG_BYTES);
                                    pend_run_next  = 1'b0;
                                    pend_kind_next = KIND_TX;
                                    pend_tx_next   = 1'b1;
                                    state_next     = ST_READ;
                                end
                            end
                        end
                    end
                    else if (!item.frame_error)
                    begin
                        if (tx_on_reg)
                        begin
                            // send completion
                            pend_run_next  = 1'b0;
                            pend_kind_next = KIND_TX;
                            pend_tx_next   = 1'b1;
                            if (count_reg == '0)
                            begin
                                tx_on_next = 1'b0;
                                send_next  = '0;
                            end
                            else if (send_inc >= len_reg[head_reg])
                            begin
                                head_next  = head_inc;
                                count_next = count_dec;
                                send_next  = '0;
                                if (count_dec == '0)
                                begin
                                    tx_on_next = 1'b0;
                                end
                                else
                                begin
                                    rd_addr_next = SAW'(head_inc) * SAW'(MSG_BYTES);
                                    state_next   = ST_READ;
                                end
                            end
                            else
                            begin
                                send_next    = send_inc;
                                rd_addr_next = SAW'(head_reg) * SAW'(MSG_BYTES) +
                                               SAW'(send_inc);
                                state_next   = ST_READ;
                            end
                        end
                        else if (rx_rem_reg == '0)
                        begin
                            // packet header byte
                            rx_we    = 1'b1;
                            rx_waddr = '0;
                            if (item.data[7:4] <= 4'd1)
                            begin
                                rx_count_next  = '0;
                                pend_run_next  = 1'b0;
                                pend_kind_next = KIND_RX;
                                pend_byte_next = item.data;
                                pend_end_next  = 1'b1;
                                pend_tx_next   = 1'b0;
                                state_next     = ST_EMIT;
                            end
                            else
                            begin
                                rx_rem_next   = RXW'(item.data[7:4] - 4'd1);
                                rx_count_next = RXW'(1);
                            end
                        end
                        else
                        begin
                            // packet body byte
                            if (rx_count_reg < RXW'(RX_MAX))
                            begin
                                rx_we        = 1'b1;
                                rx_count_new = rx_count_reg + 1'b1;
                            end
                            rx_count_next = rx_count_new;
                            rx_rem_next   = rx_rem_dec;
                            if (rx_rem_dec == '0)
                            begin
                                rx_count_next  = '0;
                                run_len_next   = rx_count_new;
                                run_idx_next   = '0;
                                pend_run_next  = 1'b1;
                                pend_kind_next = KIND_RX;
                                pend_tx_next   = 1'b0;
                                state_next     = ST_READ;
                            end
                        end
                    end
                end
            end

            ST_READ:
            begin
                state_next = ST_CAPTURE;
            end

            ST_CAPTURE:
            begin
                pend_byte_next = pend_run_reg ? rx_rdata : store_rdata;
                pend_end_next  = pend_run_reg && run_last;
                state_next     = ST_EMIT;
            end

            ST_EMIT:
            begin
                if (!out_valid_reg || res_ch.ready)
                begin
                    out_valid_next           = 1'b1;
                    out_item_next.kind       = pend_kind_reg;
                    out_item_next.byte_out   = pend_byte_reg;
                    out_item_next.end_of_run = pend_end_reg;
                    out_item_next.tx_on      = pend_tx_reg;
                    if (pend_run_reg && !run_last)
                    begin
                        run_idx_next = run_idx_reg + 1'b1;
                        state_next   = ST_READ;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            fill_reg      <= '0;
            refused_reg   <= 1'b0;
            send_reg      <= '0;
            tx_on_reg     <= 1'b0;
            rx_count_reg  <= '0;
            rx_rem_reg    <= '0;
            run_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            fill_reg      <= fill_next;
            refused_reg   <= refused_next;
            send_reg      <= send_next;
            tx_on_reg     <= tx_on_next;
            rx_count_reg  <= rx_count_next;
            rx_rem_reg    <= rx_rem_next;
            run_idx_reg   <= run_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        run_len_reg   <= run_len_next;
        pend_run_reg  <= pend_run_next;
        pend_kind_reg <= pend_kind_next;
        pend_byte_reg <= pend_byte_next;
        pend_end_reg  <= pend_end_next;
        pend_tx_reg   <= pend_tx_next;
        rd_addr_reg   <= rd_addr_next;
        out_item_reg  <= out_item_next;
    end

    // message length table
    always_ff @(posedge clk)
    begin
        if (len_we)
        begin
            len_reg[len_waddr] <= len_wdata;
        end
    end

    // message byte store
    hdpf_ram #(
        .WIDTH (8),
        .DEPTH (SDEPTH)
    ) u_store_ram (
        .clk   (clk),
        .we    (store_we),
        .waddr (store_waddr),
        .wdata (item.data),
        .raddr (rd_addr_reg),
        .rdata (store_rdata)
    );

    // received packet buffer
    hdpf_ram #(
        .WIDTH (8),
        .DEPTH (RX_MAX)
    ) u_rx_ram (
        .clk   (clk),
        .we    (rx_we),
        .waddr (rx_waddr),
        .wdata (item.data),
        .raddr (run_idx_reg),
        .rdata (rx_rdata)
    );

endmodule

// ===== design/hdpf_ram.sv =====
// ----------------------------------------------------------------------------
// hdpf_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module hdpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/hdpf_checker.sv =====
// ----------------------------------------------------------------------------
// hdpf_checker
// Port-level checks on the framer's result channel, bound to the top level.
// ----------------------------------------------------------------------------
module hdpf_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       valid,
    input logic       ready,
    input logic [1:0] kind,
    input logic [7:0] byte_out,
    input logic       end_of_run,
    input logic       tx_on
);
    import hdpf_pkg::*;

    // a stalled result holds until its transfer
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid && $stable(kind) && $stable(byte_out) &&
        $stable(end_of_run) && $stable(tx_on))
        else $error("result changed while stalled");

    // only defined kinds are emitted
    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> (kind == KIND_TX || kind == KIND_RX || kind == KIND_REFUSE))
        else $error("undefined result kind");

    // end of run only on received packet bytes
    a_end: assert property (@(posedge clk) disable iff (!rst_n)
        valid && end_of_run |-> kind == KIND_RX)
        else $error("end of run on a non-packet result");

    // a refusal carries a zero byte
    a_refuse: assert property (@(posedge clk) disable iff (!rst_n)
        valid && kind == KIND_REFUSE |-> byte_out == 8'h00)
        else $error("refusal with non-zero byte");

    // bytes to transmit only while the transmitter is on
    a_tx: assert property (@(posedge clk) disable iff (!rst_n)
        valid && kind == KIND_TX |-> tx_on)
        else $error("transmit byte with transmitter off");

endmodule

bind half_duplex_packet_framer hdpf_checker u_hdpf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .valid      (res_ch.valid),
    .ready      (res_ch.ready),
    .kind       (res_ch.item.kind),
    .byte_out   (res_ch.item.byte_out),
    .end_of_run (res_ch.item.end_of_run),
    .tx_on      (res_ch.item.tx_on)
);

// ===== tb/half_duplex_packet_framer_tb.sv =====
// ----------------------------------------------------------------------------
// half_duplex_packet_framer_tb
// Self-checking bench for the half-duplex packet framer. A short table of
// directed items is followed by random message and packet traffic. Every
// result transfer is checked against a behavioural copy of the framer held
// in the bench, or against the table entry for typed directed rows. The
// sender works in bursts, the receiver stalls at random, and one long
// receiver hold-off backs the block up.
module half_duplex_packet_framer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hdpf_pkg::*;

    localparam int QD           = 4;
    localparam int MB           = 32;
    localparam int RAND_ITEMS   = 80;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 100;
    localparam int LIMIT        = 200000;

    // how a directed row is checked
    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_SILENT,
        CHK_TYPED
    } chk_t;

    typedef struct packed {
        in_item_t  item;
        chk_t      chk;
        out_item_t res;
    } dir_row_t;

    logic clk;
    logic rst_n;

    hdpf_in_if  cmd_ch ();
    hdpf_out_if res_ch ();

    half_duplex_packet_framer #(
        .QUEUE_DEPTH (QD),
        .MSG_BYTES   (MB)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd_ch (cmd_ch.sink),
        .res_ch (res_ch.source)
    );

    // framer state as the bench sees it
    logic [7:0] q_bytes [QD][MB];
    int         q_len [QD];
    int         q_head;
    int         q_count;
    int         fill_idx;
    bit         fill_drop;
    int         send_idx;
    bit         tx_busy;
    logic [7:0] rx_buf [RX_MAX];
    int         rx_got;
    int         rx_left;

    out_item_t  step_res [$];
    out_item_t  pending_res [$];
    dir_row_t   dir_rows [$];

    int         cycles;
    int         errors;
    int         in_transfers;
    int         useful_items;
    int         checked;
    int         refusals;
    int         rx_runs;
    int         burst_left;
    int         held_cycles;
    bit         hold_req;
    out_item_t  got_res;
    out_item_t  want_res;

    // clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
    end

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= 30)
            $display("[cycle %0d] mismatch: %s", cycles, msg);
    endtask

    // expected results in arrival order
    function automatic void expect_result(input out_item_t r);
        pending_res.insert(pending_res.size(), r);
    endfunction

    function automatic in_item_t make_item(input logic cmd, input logic [7:0] data,
                                           input logic last, input logic ferr);
        in_item_t it;
        it.cmd         = cmd;
        it.data        = data;
        it.last        = last;
        it.frame_error = ferr;
        return it;
    endfunction

    function automatic void add_result(input logic [1:0] kind, input logic [7:0] b,
                                       input logic eor);
        out_item_t r;
        r.kind       = kind;
        r.byte_out   = b;
        r.end_of_run = eor;
        r.tx_on      = tx_busy;
        step_res.insert(step_res.size(), r);
    endfunction

    // advance the framer copy by one item, results land in step_res
    function automatic void predict_framer(input in_item_t it);
        int slot;
        int n;
        step_res.delete();
        if (it.cmd == CMD_MSG)
        begin
            slot = (q_head + q_count) % QD;
            if (fill_idx == 0 && !fill_drop && q_count >= QD)
                fill_drop = 1'b1;
            if (fill_drop)
            begin
                if (it.last)
                begin
                    fill_drop = 1'b0;
                    fill_idx  = 0;
                    refusals++;
                    add_result(KIND_REFUSE, 8'h00, 1'b0);
                end
                return;
            end
            // bytes past the slot size are dropped
            if (fill_idx < MB)
            begin
                q_bytes[slot][fill_idx] = it.data;
                fill_idx++;
            end
            if (!it.last)
                return;
            q_len[slot] = fill_idx;
            q_count++;
            fill_idx = 0;
            if (!tx_busy)
            begin
                tx_busy  = 1'b1;
                send_idx = 0;
                add_result(KIND_TX, q_bytes[q_head][0], 1'b0);
            end
            return;
        end
        if (it.frame_error)
            return;
        // line event while sending: previous byte has gone
        if (tx_busy)
        begin
            if (q_count == 0)
            begin
                tx_busy  = 1'b0;
                send_idx = 0;
                return;
            end
            send_idx++;
            if (send_idx >= q_len[q_head])
            begin
                q_head = (q_head + 1) % QD;
                q_count--;
                send_idx = 0;
                if (q_count == 0)
                begin
                    tx_busy = 1'b0;
                    return;
                end
                add_result(KIND_TX, q_bytes[q_head][0], 1'b0);
                return;
            end
            add_result(KIND_TX, q_bytes[q_head][send_idx], 1'b0);
            return;
        end
        // receive side, header nibble gives packet length
        if (rx_left == 0)
        begin
            n         = int'(it.data[7:4]);
            rx_buf[0] = it.data;
            if (n <= 1)
            begin
                rx_got = 0;
                rx_runs++;
                add_result(KIND_RX, it.data, 1'b1);
                return;
            end
            rx_left = n - 1;
            rx_got  = 1;
            return;
        end
        if (rx_got < RX_MAX)
        begin
            rx_buf[rx_got] = it.data;
            rx_got++;
        end
        rx_left--;
        if (rx_left == 0)
        begin
            for (int k = 0; k < rx_got; k++)
                add_result(KIND_RX, rx_buf[k], (k == rx_got - 1));
            rx_got = 0;
            rx_runs++;
        end
    endfunction

    // one input transfer, with burst gaps on the sender side
    task automatic send_item(input in_item_t it, input chk_t chk, input out_item_t typed);
        if (burst_left == 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.item  <= it;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        burst_left--;
        in_transfers++;
        if (!(it.cmd == CMD_LINE && it.frame_error))
            useful_items++;
        predict_framer(it);
        case (chk)
            CHK_TYPED:  expect_result(typed);
            CHK_SILENT: ;
            default:
            begin
                foreach (step_res[i])
                    expect_result(step_res[i]);
            end
        endcase
    endtask

    task automatic send_plain(input in_item_t it);
        send_item(it, CHK_MODEL, '0);
    endtask

    task automatic send_message(input int len);
        for (int i = 0; i < len; i++)
            send_plain(make_item(CMD_MSG, 8'($urandom), (i == len - 1),
                                 1'($urandom_range(0, 1))));
    endtask

    // header then body, with stray framing errors in between
    task automatic send_packet(input int nib);
        send_plain(make_item(CMD_LINE, {nib[3:0], 4'($urandom)},
                             1'($urandom_range(0, 1)), 1'b0));
        for (int i = 1; i < nib; i++)
        begin
            if ($urandom_range(0, 6) == 0)
                send_plain(make_item(CMD_LINE, 8'($urandom),
                                     1'($urandom_range(0, 1)), 1'b1));
            send_plain(make_item(CMD_LINE, 8'($urandom),
                                 1'($urandom_range(0, 1)), 1'b0));
        end
    endtask

    function automatic int msg_len();
        int p;
        p = $urandom_range(0, 19);
        if (p < 16)
            return $urandom_range(1, 6);
        else if (p < 19)
            return $urandom_range(7, MB);
        return $urandom_range(MB + 1, MB + 8);
    endfunction

    function automatic dir_row_t row(input logic cmd, input logic [7:0] data,
                                     input logic last, input logic ferr, input chk_t chk,
                                     input logic [1:0] kind, input logic [7:0] b,
                                     input logic eor, input logic txo);
        dir_row_t r;
        r.item           = make_item(cmd, data, last, ferr);
        r.chk            = chk;
        r.res.kind       = kind;
        r.res.byte_out   = b;
        r.res.end_of_run = eor;
        r.res.tx_on      = txo;
        return r;
    endfunction

    function automatic void add_row(input dir_row_t r);
        dir_rows.insert(dir_rows.size(), r);
    endfunction

    // directed items
    task automatic load_table();
        // one-byte packets straight after reset, header nibble 0 and 1
        add_row(row(CMD_LINE, 8'h00, 1'b0, 1'b0, CHK_TYPED, KIND_RX, 8'h00, 1'b1, 1'b0));
        add_row(row(CMD_LINE, 8'h1F, 1'b0, 1'b0, CHK_TYPED, KIND_RX, 8'h1F, 1'b1, 1'b0));
        // framing error changes nothing
        add_row(row(CMD_LINE, 8'hFF, 1'b1, 1'b1, CHK_SILENT, KIND_TX, 8'h00, 1'b0, 1'b0));
        // three-byte packet
        add_row(row(CMD_LINE, 8'h30, 1'b0, 1'b0, CHK_MODEL, KIND_TX, 8'h00, 1'b0, 1'b0));
        add_row(row(CMD_LINE, 8'hAB, 1'b1, 1'b0, CHK_MODEL, KIND_TX, 8'h00, 1'b0, 1'b0));
        add_row(row(CMD_LINE, 8'h55, 1'b0, 1'b0, CHK_MODEL, KIND_TX, 8'h00, 1'b0, 1'b0));
        // two-byte message, commit starts the transmitter
        add_row(row(CMD_MSG, 8'hFF, 1'b0, 1'b1, CHK_MODEL, KIND_TX, 8'h00, 1'b0, 1'b0));
        add_row(row(CMD_MSG, 8'h00, 1'b1, 1'b0, CHK_TYPED, KIND_TX, 8'hFF, 1'b0, 1'b1));
        add_row(row(CMD_LINE, 8'h00, 1'b0, 1'b0, CHK_MODEL, KIND_TX, 8'h00, 1'b0, 1'b0));
        add_row(row(CMD_LINE, 8'h00, 1'b0, 1'b1, CHK_SILENT, KIND_TX, 8'h00, 1'b0, 1'b0));
        // end of queue turns the transmitter off silently
        add_row(row(CMD_LINE, 8'hF5, 1'b1, 1'b0, CHK_MODEL, KIND_TX, 8'h00, 1'b0, 1'b0));
        // fill every slot, then a refused message
        add_row(row(CMD_MSG, 8'hA1, 1'b1, 1'b0, CHK_MODEL, KIND_TX, 8'h00, 1'b0, 1'b0));
        add_row(row(CMD_MSG, 8'hA2, 1'b1, 1'b0, CHK_MODEL, KIND_TX, 8'h00, 1'b0, 1'b0));
        add_row(row(CMD_MSG, 8'hA3, 1'b1, 1'b0, CHK_MODEL, KIND_TX, 8'h00, 1'b0, 1'b0));
        add_row(row(CMD_MSG, 8'hA4, 1'b1, 1'b0, CHK_MODEL, KIND_TX, 8'h00, 1'b0, 1'b0));
        add_row(row(CMD_MSG, 8'h11, 1'b0, 1'b0, CHK_MODEL, KIND_TX, 8'h00, 1'b0, 1'b0));
        add_row(row(CMD_MSG, 8'h22, 1'b1, 1'b0, CHK_TYPED, KIND_REFUSE, 8'h00, 1'b0, 1'b1));
        // header-like line bytes while sending are completions only
        add_row(row(CMD_LINE, 8'hF0, 1'b0, 1'b0, CHK_MODEL, KIND_TX, 8'h00, 1'b0, 1'b0));
        add_row(row(CMD_LINE, 8'hF0, 1'b0, 1'b0, CHK_MODEL, KIND_TX, 8'h00, 1'b0, 1'b0));
        add_row(row(CMD_LINE, 8'hF0, 1'b0, 1'b0, CHK_MODEL, KIND_TX, 8'h00, 1'b0, 1'b0));
        add_row(row(CMD_LINE, 8'hF0, 1'b0, 1'b0, CHK_MODEL, KIND_TX, 8'h00, 1'b0, 1'b0));
        // receiver left idle by the traffic above
        add_row(row(CMD_LINE, 8'h0F, 1'b0, 1'b0, CHK_TYPED, KIND_RX, 8'h0F, 1'b1, 1'b0));
    endtask

    // random traffic, mostly well-formed messages and packets
    task automatic run_random();
        int pick;
        int target;
        bit hold_done;
        target    = useful_items + RAND_ITEMS;
        hold_done = 1'b0;
        while (useful_items < target)
        begin
            if (!hold_done && useful_items >= target - RAND_ITEMS + 25)
            begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (tx_busy)
            begin
                if (pick < 55)
                    send_plain(make_item(CMD_LINE, 8'($urandom), 1'($urandom_range(0, 1)),
                                         ($urandom_range(0, 9) == 0)));
                else if (pick < 82)
                    send_message(msg_len());
                else if (pick < 90)
                    repeat (5) send_message($urandom_range(1, 2));
                else
                    send_plain(make_item(1'($urandom_range(0, 1)), 8'($urandom),
                                         1'($urandom_range(0, 1)),
                                         1'($urandom_range(0, 1))));
            end
            else
            begin
                if (pick < 30)
                    send_message(msg_len());
                else if (pick < 82)
                    send_packet($urandom_range(0, 15));
                else
                    send_plain(make_item(1'($urandom_range(0, 1)), 8'($urandom),
                                         1'($urandom_range(0, 1)),
                                         1'($urandom_range(0, 1))));
            end
        end
    endtask

    // receiver stall pattern, plus one long hold-off on request
    initial
    begin
        int mode_left;
        int pct;
        res_ch.ready <= 1'b0;
        mode_left = 0;
        pct       = 100;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES)
                begin
                    @(posedge clk);
                    held_cycles++;
                end
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode_left = $urandom_range(50, 200);
                    case ($urandom_range(0, 2))
                        0:       pct = 100;
                        1:       pct = 75;
                        default: pct = 30;
                    endcase
                end
                mode_left--;
                res_ch.ready <= ($urandom_range(0, 99) < pct);
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got_res = res_ch.item;
            checked++;
            if (pending_res.size() == 0)
                report_mismatch($sformatf("result %p with nothing expected", got_res));
            else
            begin
                want_res = pending_res[0];
                pending_res.delete(0);
                if (got_res.kind !== want_res.kind)
                    report_mismatch($sformatf("kind %0d, expected %0d",
                                              got_res.kind, want_res.kind));
                if (got_res.byte_out !== want_res.byte_out)
                    report_mismatch($sformatf("byte_out %02h, expected %02h",
                                              got_res.byte_out, want_res.byte_out));
                if (got_res.end_of_run !== want_res.end_of_run)
                    report_mismatch($sformatf("end_of_run %0b, expected %0b",
                                              got_res.end_of_run, want_res.end_of_run));
                if (got_res.tx_on !== want_res.tx_on)
                    report_mismatch($sformatf("tx_on %0b, expected %0b",
                                              got_res.tx_on, want_res.tx_on));
            end
        end
    end

    // watchdog
    initial
    begin
        wait (cycles >= LIMIT);
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycles, pending_res.size());
        $display("FAIL");
        $finish;
    end

    // main sequence
    initial
    begin
        cycles       = 0;
        errors       = 0;
        in_transfers = 0;
        useful_items = 0;
        checked      = 0;
        refusals     = 0;
        rx_runs      = 0;
        burst_left   = 0;
        held_cycles  = 0;
        hold_req     = 1'b0;
        q_head       = 0;
        q_count      = 0;
        fill_idx     = 0;
        fill_drop    = 1'b0;
        send_idx     = 0;
        tx_busy      = 1'b0;
        rx_got       = 0;
        rx_left      = 0;
        rst_n        <= 1'b0;
        cmd_ch.valid <= 1'b0;
        cmd_ch.item  <= '0;
        load_table();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_item(dir_rows[i].item, dir_rows[i].chk, dir_rows[i].res);
        run_random();
        cmd_ch.valid <= 1'b0;

        // let outstanding results drain, then watch for strays
        wait (pending_res.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d input transfers and %0d checked results", in_transfers, checked);
        $display("including %0d refused messages, %0d received runs, %0d-cycle hold-off",
                 refusals, rx_runs, held_cycles);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
